### rtl/core/assert_macros.svh
// assertion macros shared by wsmm_sdiv and the top level of the windowed statistics block
// depends on nothing; taken in by `include where a module asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and synchronous reset
`define ASSERT_ON_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same, on the house clock and reset names
`define ASSERT_ALWAYS(label, prop, msg) \
   `ASSERT_ON_CLK(label, clock, reset, prop, msg)

`endif

### rtl/core/wsmm_pkg.sv
// shared types and constants of the windowed min / max / mean statistics block
// depends on nothing; used by wsmm_accum and the top level under rtl/core
package wsmm_pkg;

   localparam int TEMP_W      = 15;
   localparam int HUM_W       = 14;
   localparam int PRES_W      = 17;
   localparam int TS_W        = 32;
   localparam int CSR_W       = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int SLOT_OUT_W  = 5;
   localparam int COUNT_OUT_W = 16;

   localparam int HISTORY_DEPTH_DEF = 24;
   localparam int COUNT_BITS_DEF    = 16;

   localparam logic [CSR_W-1:0] WINDOW_LENGTH_RST = 32'd3600000;
   localparam logic [CSR_W-1:0] FIRST_START_RST   = 32'd0;

   // per-window starting points of the running minima and maxima
   localparam logic signed [TEMP_W-1:0] TEMP_MIN_INIT = 15'h3FFF;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX_INIT = 15'h4000;
   localparam logic [HUM_W-1:0]         HUM_MIN_INIT  = 14'h3FFF;
   localparam logic [HUM_W-1:0]         HUM_MAX_INIT  = 14'h0000;
   localparam logic [PRES_W-1:0]        PRES_MIN_INIT = 17'h1FFFF;
   localparam logic [PRES_W-1:0]        PRES_MAX_INIT = 17'h00000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LENGTH = 2'd0,
      CSR_FIRST_START   = 2'd1
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_LOAD
   } ctl_state_type;

   // accumulator control: add the sample, and restart the window before adding
   typedef struct packed {
      logic add;
      logic restart;
   } acc_ctrl_type;

endpackage

### rtl/core/wsmm_sdiv.sv
// restoring bit-serial divider, one quotient bit per cycle
// depends on assert_macros.svh; uses nothing from wsmm_pkg
`include "assert_macros.svh"

module wsmm_sdiv #(
   parameter int NUM_W  = 31,
   parameter int QUOT_W = 15
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [NUM_W-1:0]          num,
   input  logic [NUM_W-QUOT_W-1:0]   den,
   output logic                      busy,
   output logic [QUOT_W-1:0]         quot
);

   localparam int DEN_W  = NUM_W - QUOT_W;
   localparam int STEP_W = $clog2(QUOT_W + 1);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUOT_W - 1);

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [QUOT_W-1:0] sh_ff, sh_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [DEN_W:0]    shifted;
   logic [DEN_W+1:0]  diff;
   logic              fits;

   // partial remainder with the next numerator bit, minus the divisor
   always_comb begin
      shifted = {rem_ff, sh_ff[QUOT_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      fits    = !diff[DEN_W+1];
   end

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      sh_in   = sh_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = num[NUM_W-1:QUOT_W];
         sh_in   = num[QUOT_W-1:0];
         den_in  = den;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         sh_in   = {sh_ff[QUOT_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      sh_ff  <= sh_in;
   end

   assign busy = busy_ff;
   assign quot = sh_ff;

   `ASSERT_ALWAYS(a_rem_below_den, busy_ff && den_ff != '0 |-> rem_ff < den_ff, "remainder reached divisor")
   `ASSERT_ALWAYS(a_step_bound, busy_ff |-> step_ff <= STEP_LAST, "divider ran past last step")

endmodule

### rtl/core/wsmm_accum.sv
// per-window running minima, maxima, sums and saturating sample count
// depends on wsmm_pkg
module wsmm_accum #(
   parameter int COUNT_BITS = wsmm_pkg::COUNT_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  wsmm_pkg::acc_ctrl_type                      ctrl,
   input  logic signed [wsmm_pkg::TEMP_W-1:0]          temperature,
   input  logic [wsmm_pkg::HUM_W-1:0]                  humidity,
   input  logic [wsmm_pkg::PRES_W-1:0]                 pressure,
   output logic [COUNT_BITS-1:0]                       count,
   output logic signed [wsmm_pkg::TEMP_W+COUNT_BITS-1:0] temp_sum,
   output logic [wsmm_pkg::HUM_W+COUNT_BITS-1:0]       hum_sum,
   output logic [wsmm_pkg::PRES_W+COUNT_BITS-1:0]      pres_sum,
   output logic signed [wsmm_pkg::TEMP_W-1:0]          temp_min,
   output logic signed [wsmm_pkg::TEMP_W-1:0]          temp_max,
   output logic [wsmm_pkg::HUM_W-1:0]                  hum_min,
   output logic [wsmm_pkg::HUM_W-1:0]                  hum_max,
   output logic [wsmm_pkg::PRES_W-1:0]                 pres_min,
   output logic [wsmm_pkg::PRES_W-1:0]                 pres_max
);

   localparam int TSUM_W = wsmm_pkg::TEMP_W + COUNT_BITS;
   localparam int HSUM_W = wsmm_pkg::HUM_W + COUNT_BITS;
   localparam int PSUM_W = wsmm_pkg::PRES_W + COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] CNT_LIMIT = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0]                    cnt_ff, cnt_in, b_cnt;
   logic signed [TSUM_W-1:0]                 tsum_ff, tsum_in, b_tsum;
   logic [HSUM_W-1:0]                        hsum_ff, hsum_in, b_hsum;
   logic [PSUM_W-1:0]                        psum_ff, psum_in, b_psum;
   logic signed [wsmm_pkg::TEMP_W-1:0]       tmin_ff, tmin_in, b_tmin;
   logic signed [wsmm_pkg::TEMP_W-1:0]       tmax_ff, tmax_in, b_tmax;
   logic [wsmm_pkg::HUM_W-1:0]               hmin_ff, hmin_in, b_hmin;
   logic [wsmm_pkg::HUM_W-1:0]               hmax_ff, hmax_in, b_hmax;
   logic [wsmm_pkg::PRES_W-1:0]              pmin_ff, pmin_in, b_pmin;
   logic [wsmm_pkg::PRES_W-1:0]              pmax_ff, pmax_in, b_pmax;

   // starting point: a fresh window or the running one
   always_comb begin
      if (ctrl.restart) begin
         b_cnt  = '0;
         b_tsum = '0;
         b_hsum = '0;
         b_psum = '0;
         b_tmin = wsmm_pkg::TEMP_MIN_INIT;
         b_tmax = wsmm_pkg::TEMP_MAX_INIT;
         b_hmin = wsmm_pkg::HUM_MIN_INIT;
         b_hmax = wsmm_pkg::HUM_MAX_INIT;
         b_pmin = wsmm_pkg::PRES_MIN_INIT;
         b_pmax = wsmm_pkg::PRES_MAX_INIT;
      end else begin
         b_cnt  = cnt_ff;
         b_tsum = tsum_ff;
         b_hsum = hsum_ff;
         b_psum = psum_ff;
         b_tmin = tmin_ff;
         b_tmax = tmax_ff;
         b_hmin = hmin_ff;
         b_hmax = hmax_ff;
         b_pmin = pmin_ff;
         b_pmax = pmax_ff;
      end
   end

   always_comb begin
      cnt_in  = b_cnt;
      tsum_in = b_tsum;
      hsum_in = b_hsum;
      psum_in = b_psum;
      tmin_in = b_tmin;
      tmax_in = b_tmax;
      hmin_in = b_hmin;
      hmax_in = b_hmax;
      pmin_in = b_pmin;
      pmax_in = b_pmax;
      if (ctrl.add) begin
         if (temperature < b_tmin) tmin_in = temperature;
         if (temperature > b_tmax) tmax_in = temperature;
         if (humidity < b_hmin)    hmin_in = humidity;
         if (humidity > b_hmax)    hmax_in = humidity;
         if (pressure < b_pmin)    pmin_in = pressure;
         if (pressure > b_pmax)    pmax_in = pressure;
         // past saturation only the extremes move
         if (b_cnt != CNT_LIMIT) begin
            cnt_in  = b_cnt + COUNT_BITS'(1);
            tsum_in = b_tsum + TSUM_W'(temperature);
            hsum_in = b_hsum + HSUM_W'(humidity);
            psum_in = b_psum + PSUM_W'(pressure);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         tsum_ff <= '0;
         hsum_ff <= '0;
         psum_ff <= '0;
         tmin_ff <= wsmm_pkg::TEMP_MIN_INIT;
         tmax_ff <= wsmm_pkg::TEMP_MAX_INIT;
         hmin_ff <= wsmm_pkg::HUM_MIN_INIT;
         hmax_ff <= wsmm_pkg::HUM_MAX_INIT;
         pmin_ff <= wsmm_pkg::PRES_MIN_INIT;
         pmax_ff <= wsmm_pkg::PRES_MAX_INIT;
      end else begin
         cnt_ff  <= cnt_in;
         tsum_ff <= tsum_in;
         hsum_ff <= hsum_in;
         psum_ff <= psum_in;
         tmin_ff <= tmin_in;
         tmax_ff <= tmax_in;
         hmin_ff <= hmin_in;
         hmax_ff <= hmax_in;
         pmin_ff <= pmin_in;
         pmax_ff <= pmax_in;
      end
   end

   assign count    = cnt_ff;
   assign temp_sum = tsum_ff;
   assign hum_sum  = hsum_ff;
   assign pres_sum = psum_ff;
   assign temp_min = tmin_ff;
   assign temp_max = tmax_ff;
   assign hum_min  = hmin_ff;
   assign hum_max  = hmax_ff;
   assign pres_min = pmin_ff;
   assign pres_max = pmax_ff;

endmodule

### rtl/core/windowed_sensor_min_max_mean.sv
// top level of the windowed min / max / mean statistics block
// depends on wsmm_pkg, wsmm_accum, wsmm_sdiv and assert_macros.svh
//
//   channel  direction  handshake                   carries
//   req_     in         req_valid / req_stall       one sample with timestamp
//   rsp_     out        rsp_valid / rsp_stall       statistics of a closed window
//   csr_     in         csr_write, csr_index        window_length, first_window_start
//
// a sample inside the current window is taken without a stall: req_stall stays low
// a sample that closes a window is taken, then req_stall stays high until the result loads: the three
//   serial dividers run in parallel, the widest quotient (pressure) sets the length of the stall,
//   ST_DIV sees them done and ST_LOAD loads the result, from which rsp_valid is registered
// rsp_stall only holds ST_LOAD while the output register is still full
// reset is synchronous and active high; no clearing pass is needed
`include "assert_macros.svh"

module windowed_sensor_min_max_mean #(
   parameter int HISTORY_DEPTH = wsmm_pkg::HISTORY_DEPTH_DEF,
   parameter int COUNT_BITS    = wsmm_pkg::COUNT_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // sample input
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [wsmm_pkg::TEMP_W-1:0]     req_temperature,
   input  logic [wsmm_pkg::HUM_W-1:0]             req_humidity,
   input  logic [wsmm_pkg::PRES_W-1:0]            req_pressure,
   input  logic [wsmm_pkg::TS_W-1:0]              req_timestamp,
   // window results
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [wsmm_pkg::SLOT_OUT_W-1:0]        rsp_slot,
   output logic signed [wsmm_pkg::TEMP_W-1:0]     rsp_temp_min,
   output logic signed [wsmm_pkg::TEMP_W-1:0]     rsp_temp_max,
   output logic signed [wsmm_pkg::TEMP_W-1:0]     rsp_temp_mean,
   output logic [wsmm_pkg::HUM_W-1:0]             rsp_hum_min,
   output logic [wsmm_pkg::HUM_W-1:0]             rsp_hum_max,
   output logic [wsmm_pkg::HUM_W-1:0]             rsp_hum_mean,
   output logic [wsmm_pkg::PRES_W-1:0]            rsp_pres_min,
   output logic [wsmm_pkg::PRES_W-1:0]            rsp_pres_max,
   output logic [wsmm_pkg::PRES_W-1:0]            rsp_pres_mean,
   output logic [wsmm_pkg::COUNT_OUT_W-1:0]       rsp_sample_count,
   // configuration writes
   input  logic                                   csr_write,
   input  logic [wsmm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [wsmm_pkg::CSR_W-1:0]             csr_wdata
);

   localparam int TEMP_W  = wsmm_pkg::TEMP_W;
   localparam int HUM_W   = wsmm_pkg::HUM_W;
   localparam int PRES_W  = wsmm_pkg::PRES_W;
   localparam int TS_W    = wsmm_pkg::TS_W;
   localparam int SOUT_W  = wsmm_pkg::SLOT_OUT_W;
   localparam int COUT_W  = wsmm_pkg::COUNT_OUT_W;
   localparam int TSUM_W  = TEMP_W + COUNT_BITS;
   localparam int HSUM_W  = HUM_W + COUNT_BITS;
   localparam int PSUM_W  = PRES_W + COUNT_BITS;
   localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

   // ---------------------------------------------------------------
   // configuration and window bookkeeping
   // ---------------------------------------------------------------
   logic [TS_W-1:0]   wlen_ff, wlen_in;
   logic [TS_W-1:0]   fstart_ff, fstart_in;
   logic [TS_W-1:0]   wend_ff, wend_in;
   logic              started_ff, started_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              csr_hit;

   wsmm_pkg::ctl_state_type state_ff, state_in;

   logic accept;
   logic close;
   logic out_free;
   logic load;

   // a transfer on the input side only while no window is being closed
   assign req_stall = (state_ff != wsmm_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   // timestamps compare unsigned, window ends wrap modulo 2^32
   assign close     = accept && (req_timestamp > wend_ff);

   always_comb begin
      wlen_in   = wlen_ff;
      fstart_in = fstart_ff;
      csr_hit   = 1'b0;
      if (csr_write) begin
         if (csr_index == wsmm_pkg::CSR_WINDOW_LENGTH) begin
            wlen_in = csr_wdata;
            csr_hit = 1'b1;
         end else if (csr_index == wsmm_pkg::CSR_FIRST_START) begin
            fstart_in = csr_wdata;
            csr_hit   = 1'b1;
         end
      end
   end

   always_comb begin
      wend_in    = wend_ff;
      slot_in    = slot_ff;
      started_in = started_ff | accept;
      priority if (close) begin
         wend_in = req_timestamp + wlen_ff;
         slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);
      end else if (csr_hit && !started_ff) begin
         // before the first sample the first window follows the registers
         wend_in = fstart_in + wlen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff    <= wsmm_pkg::WINDOW_LENGTH_RST;
         fstart_ff  <= wsmm_pkg::FIRST_START_RST;
         wend_ff    <= wsmm_pkg::FIRST_START_RST + wsmm_pkg::WINDOW_LENGTH_RST;
         started_ff <= 1'b0;
         slot_ff    <= '0;
      end else begin
         wlen_ff    <= wlen_in;
         fstart_ff  <= fstart_in;
         wend_ff    <= wend_in;
         started_ff <= started_in;
         slot_ff    <= slot_in;
      end
   end

   // ---------------------------------------------------------------
   // running window statistics
   // ---------------------------------------------------------------
   wsmm_pkg::acc_ctrl_type acc_ctrl;

   logic [COUNT_BITS-1:0]        acc_count;
   logic signed [TSUM_W-1:0]     acc_tsum;
   logic [HSUM_W-1:0]            acc_hsum;
   logic [PSUM_W-1:0]            acc_psum;
   logic signed [TEMP_W-1:0]     acc_tmin, acc_tmax;
   logic [HUM_W-1:0]             acc_hmin, acc_hmax;
   logic [PRES_W-1:0]            acc_pmin, acc_pmax;

   // the closing sample opens the next window as its first member
   assign acc_ctrl.add     = accept;
   assign acc_ctrl.restart = close;

   wsmm_accum #(
      .COUNT_BITS (COUNT_BITS)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (acc_ctrl),
      .temperature (req_temperature),
      .humidity    (req_humidity),
      .pressure    (req_pressure),
      .count       (acc_count),
      .temp_sum    (acc_tsum),
      .hum_sum     (acc_hsum),
      .pres_sum    (acc_psum),
      .temp_min    (acc_tmin),
      .temp_max    (acc_tmax),
      .hum_min     (acc_hmin),
      .hum_max     (acc_hmax),
      .pres_min    (acc_pmin),
      .pres_max    (acc_pmax)
   );

   // ---------------------------------------------------------------
   // serial division of the closed window's sums by its count
   // ---------------------------------------------------------------
   logic              tsum_neg;
   logic [TSUM_W-1:0] tsum_mag;
   logic              tdiv_busy, hdiv_busy, pdiv_busy;
   logic [TEMP_W-1:0] tdiv_quot;
   logic [HUM_W-1:0]  hdiv_quot;
   logic [PRES_W-1:0] pdiv_quot;
   logic              divs_busy;

   // temperature divides by magnitude, the sign goes back on afterwards
   assign tsum_neg = acc_tsum[TSUM_W-1];
   assign tsum_mag = tsum_neg ? TSUM_W'(-acc_tsum) : TSUM_W'(acc_tsum);

   wsmm_sdiv #(
      .NUM_W  (TSUM_W),
      .QUOT_W (TEMP_W)
   ) u_tdiv (
      .clock (clock),
      .reset (reset),
      .start (close),
      .num   (tsum_mag),
      .den   (acc_count),
      .busy  (tdiv_busy),
      .quot  (tdiv_quot)
   );

   wsmm_sdiv #(
      .NUM_W  (HSUM_W),
      .QUOT_W (HUM_W)
   ) u_hdiv (
      .clock (clock),
      .reset (reset),
      .start (close),
      .num   (acc_hsum),
      .den   (acc_count),
      .busy  (hdiv_busy),
      .quot  (hdiv_quot)
   );

   wsmm_sdiv #(
      .NUM_W  (PSUM_W),
      .QUOT_W (PRES_W)
   ) u_pdiv (
      .clock (clock),
      .reset (reset),
      .start (close),
      .num   (acc_psum),
      .den   (acc_count),
      .busy  (pdiv_busy),
      .quot  (pdiv_quot)
   );

   assign divs_busy = tdiv_busy || hdiv_busy || pdiv_busy;

   // snapshot of the closed window while the dividers run
   logic [SLOT_W-1:0]        h_slot_ff;
   logic [COUNT_BITS-1:0]    h_cnt_ff;
   logic                     h_neg_ff;
   logic signed [TEMP_W-1:0] h_tmin_ff, h_tmax_ff;
   logic [HUM_W-1:0]         h_hmin_ff, h_hmax_ff;
   logic [PRES_W-1:0]        h_pmin_ff, h_pmax_ff;

   always_ff @(posedge clock) begin
      if (close) begin
         h_slot_ff <= slot_ff;
         h_cnt_ff  <= acc_count;
         h_neg_ff  <= tsum_neg;
         h_tmin_ff <= acc_tmin;
         h_tmax_ff <= acc_tmax;
         h_hmin_ff <= acc_hmin;
         h_hmax_ff <= acc_hmax;
         h_pmin_ff <= acc_pmin;
         h_pmax_ff <= acc_pmax;
      end
   end

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wsmm_pkg::ST_IDLE: begin
            if (close) state_in = wsmm_pkg::ST_DIV;
         end
         wsmm_pkg::ST_DIV: begin
            if (!divs_busy) state_in = wsmm_pkg::ST_LOAD;
         end
         wsmm_pkg::ST_LOAD: begin
            if (out_free) state_in = wsmm_pkg::ST_IDLE;
         end
         default: state_in = wsmm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      load = 1'b0;
      unique case (state_ff)
         wsmm_pkg::ST_LOAD: load = out_free;
         default:           load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsmm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SOUT_W-1:0]        o_slot_ff;
   logic [COUT_W-1:0]        o_cnt_ff;
   logic signed [TEMP_W-1:0] o_tmin_ff, o_tmax_ff, o_tmean_ff;
   logic [HUM_W-1:0]         o_hmin_ff, o_hmax_ff, o_hmean_ff;
   logic [PRES_W-1:0]        o_pmin_ff, o_pmax_ff, o_pmean_ff;

   logic [SLOT_W+SOUT_W-1:0]     slot_ext;
   logic [COUNT_BITS+COUT_W-1:0] cnt_ext;
   logic [COUT_W-1:0]            cnt_sat;
   logic                         empty;
   logic [TEMP_W-1:0]            tmean;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      slot_ext = {{SOUT_W{1'b0}}, h_slot_ff};
      cnt_ext  = {{COUT_W{1'b0}}, h_cnt_ff};
      // reported count saturates at the field's top value
      cnt_sat  = (|cnt_ext[COUNT_BITS+COUT_W-1:COUT_W]) ? {COUT_W{1'b1}}
                                                         : cnt_ext[COUT_W-1:0];
      empty    = (h_cnt_ff == '0);
      tmean    = h_neg_ff ? TEMP_W'(-tdiv_quot) : tdiv_quot;
      rsp_valid_in = load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // an empty window reports zero extremes and zero means
   always_ff @(posedge clock) begin
      if (load) begin
         o_slot_ff  <= slot_ext[SOUT_W-1:0];
         o_cnt_ff   <= cnt_sat;
         o_tmin_ff  <= empty ? '0 : h_tmin_ff;
         o_tmax_ff  <= empty ? '0 : h_tmax_ff;
         o_tmean_ff <= empty ? '0 : tmean;
         o_hmin_ff  <= empty ? '0 : h_hmin_ff;
         o_hmax_ff  <= empty ? '0 : h_hmax_ff;
         o_hmean_ff <= empty ? '0 : hdiv_quot;
         o_pmin_ff  <= empty ? '0 : h_pmin_ff;
         o_pmax_ff  <= empty ? '0 : h_pmax_ff;
         o_pmean_ff <= empty ? '0 : pdiv_quot;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot         = o_slot_ff;
   assign rsp_temp_min     = o_tmin_ff;
   assign rsp_temp_max     = o_tmax_ff;
   assign rsp_temp_mean    = o_tmean_ff;
   assign rsp_hum_min      = o_hmin_ff;
   assign rsp_hum_max      = o_hmax_ff;
   assign rsp_hum_mean     = o_hmean_ff;
   assign rsp_pres_min     = o_pmin_ff;
   assign rsp_pres_max     = o_pmax_ff;
   assign rsp_pres_mean    = o_pmean_ff;
   assign rsp_sample_count = o_cnt_ff;

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   `ASSERT_ALWAYS(a_load_after_divide, state_ff == wsmm_pkg::ST_LOAD |-> !divs_busy, "load while dividing")
   `ASSERT_ALWAYS(a_rsp_from_load, $rose(rsp_valid_ff) |-> $past(state_ff == wsmm_pkg::ST_LOAD), "result without load")
   `ASSERT_ALWAYS(a_close_reopens, close |=> acc_count == COUNT_BITS'(1), "new window not seeded by closing sample")

endmodule
